// File: rtl/core/gray_mirror_box_blur_defines.svh
// Assertion helpers used by the block's top-level RTL.
`ifndef GRAY_MIRROR_BOX_BLUR_DEFINES_SVH
`define GRAY_MIRROR_BOX_BLUR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define GMBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define GMBB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/gmbb_pkg.sv
package gmbb_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    // filter window
    localparam int WINDOW = 9;
    localparam int HALF   = WINDOW / 2;
    localparam int SPAN   = 2 * HALF + 1;
    localparam int AREA   = SPAN * SPAN;
    localparam int SLOTS  = SPAN + 1;         // gray/colour line slots
    localparam int LAG    = HALF + 1;         // output lag in rows
    localparam int SLOT_W = $clog2(SLOTS);

    // gray conversion, Q8
    localparam int W_RED   = 54;
    localparam int W_GREEN = 184;
    localparam int W_BLUE  = 18;

    // column sum, window sum and divide by AREA via reciprocal
    localparam int VS_W      = $clog2(SPAN * 255 + 1);
    localparam int HS_W      = $clog2(AREA * 255 + 1);
    localparam int DIV_SHIFT = 20;
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + AREA - 1) / AREA;
    localparam int PROD_W    = HS_W + $clog2(DIV_MULT + 1);

    // row counters
    localparam int IN_ROW_W  = 17;
    localparam int OUT_ROW_W = 16;

    // configuration
    localparam int CFG_W        = 16;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // output queue
    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic pix;        // gray value enters the column sums
        logic row_first;  // first row of the frame: column sums start at zero
        logic sub_en;     // oldest row leaves the column sums
        logic box_en;     // window sum is a valid interior result
        logic box_bank;   // result bank for the center row
    } win_ctl_t;

endpackage

// File: rtl/core/gmbb_window.sv
module gmbb_window #(
    parameter int MAX_WIDTH = gmbb_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gmbb_pkg::win_ctl_t           ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] col,
    input  logic [$clog2(MAX_WIDTH)-1:0] box_waddr,
    input  logic [7:0]                   gray_in,
    input  logic [7:0]                   gray_old,   // registered read, aligned with the registered ctl
    input  logic                         rd_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    output logic [7:0]                   box_rdata   // registered read at rd_bank, rd_col
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int VW   = gmbb_pkg::VS_W;
    localparam int HW   = gmbb_pkg::HS_W;
    localparam int PW   = gmbb_pkg::PROD_W;
    localparam int SPAN = gmbb_pkg::SPAN;

    // per-column vertical sums and two banks of finished results
    logic [VW-1:0] vs_mem  [MAX_WIDTH];
    logic [7:0]    box_mem [2][MAX_WIDTH];

    gmbb_pkg::win_ctl_t s1_ctl_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [CW-1:0]      s1_waddr_reg;
    logic [7:0]         s1_gray_reg;
    logic [VW-1:0]      vs_rd_reg;
    logic               fwd_reg;
    logic [VW-1:0]      vs_fwd_reg;
    logic [VW-1:0]      tap_reg [SPAN];
    logic [HW-1:0]      hs_reg;
    logic               s2_en_reg;
    logic               s2_bank_reg;
    logic [CW-1:0]      s2_addr_reg;
    logic [PW-1:0]      prod_reg;
    logic               s3_en_reg;
    logic               s3_bank_reg;
    logic [CW-1:0]      s3_addr_reg;
    logic [7:0]         box_rd_reg;

    logic [VW-1:0] vs_old;
    logic [VW-1:0] vs_new;
    logic [HW-1:0] hs_next;
    logic          fwd_next;

    always_comb
    begin
        if (s1_ctl_reg.row_first)
            vs_old = '0;
        else if (fwd_reg)
            vs_old = vs_fwd_reg;
        else
            vs_old = vs_rd_reg;
        vs_new = vs_old + VW'(s1_gray_reg)
                 - (s1_ctl_reg.sub_en ? VW'(gray_old) : VW'(0));
        if (s1_col_reg == '0)
            hs_next = HW'(vs_new);
        else
            hs_next = hs_reg + HW'(vs_new)
                      - ((s1_col_reg >= CW'(SPAN)) ? HW'(tap_reg[SPAN-1]) : HW'(0));
        // same column read back-to-back (one-pixel rows): take the fresh sum
        fwd_next = ctl.pix && s1_ctl_reg.pix && (col == s1_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            fwd_reg    <= 1'b0;
            s2_en_reg  <= 1'b0;
            s3_en_reg  <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            fwd_reg    <= fwd_next;
            s2_en_reg  <= s1_ctl_reg.pix && s1_ctl_reg.box_en;
            s3_en_reg  <= s2_en_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg   <= col;
        s1_waddr_reg <= box_waddr;
        s1_gray_reg  <= gray_in;
        vs_fwd_reg   <= vs_new;
        if (s1_ctl_reg.pix)
        begin
            tap_reg[0] <= vs_new;
            for (int i = 1; i < SPAN; i++)
                tap_reg[i] <= tap_reg[i-1];
            hs_reg <= hs_next;
        end
        s2_bank_reg <= s1_ctl_reg.box_bank;
        s2_addr_reg <= s1_waddr_reg;
        prod_reg    <= PW'(hs_reg) * PW'(gmbb_pkg::DIV_MULT);
        s3_bank_reg <= s2_bank_reg;
        s3_addr_reg <= s2_addr_reg;
    end

    // column sum memory: read at entry, written back in the next cycle
    always_ff @(posedge clk)
    begin
        if (s1_ctl_reg.pix)
            vs_mem[s1_col_reg] <= vs_new;
        vs_rd_reg <= vs_mem[col];
    end

    // result memory
    always_ff @(posedge clk)
    begin
        if (s3_en_reg)
            box_mem[s3_bank_reg][s3_addr_reg] <= prod_reg[gmbb_pkg::DIV_SHIFT +: 8];
        box_rd_reg <= box_mem[rd_bank][rd_col];
    end

    assign box_rdata = box_rd_reg;

endmodule

// File: rtl/core/gray_mirror_box_blur.sv
// Grayscale, left-right mirrored box blur over a raster BGR pixel stream.
// Input channel s_axis: one item per pixel, tdata = blue, green, red from bit 0;
// tuser = 1 marks a drain item. Drain items are ignored while the frame is
// still arriving; after the last row they push out the remaining results.
// Output channel m_axis: one item per pixel, tlast on the last pixel of the frame.
// Interior pixels carry the window mean on all three channels; pixels within
// the half window of an edge keep their original colour.
// Rate: one item per clock while s_axis_tready is high. Each input item (from
// row LAG on) yields the result LAG rows behind it, via the result stage and
// the output queue. Gray and colour rows sit in a slotted line memory (one
// write, two reads a cycle); per-column vertical sums are read, updated and
// written back in the next cycle, with a bypass when the same column comes
// twice in a row. A running horizontal sum feeds a reciprocal multiply, and
// the finished row lands in a two-bank result memory read on the next row.
// Stall: a three-entry output queue absorbs the in-flight result; s_axis_tready
// drops only when the queue plus the item in flight would not fit.
// Reset: counters go to frame start, registers to 640 x 480. Memories are
// not cleared; every entry is written before it is read within a frame.
// Configuration: write index 0 = image_width, 1 = image_height, while idle.
`include "gray_mirror_box_blur_defines.svh"

module gray_mirror_box_blur #(
    parameter int MAX_WIDTH = gmbb_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // config write port
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [gmbb_pkg::CFG_W-1:0] cfg_wdata,
    // input pixels
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,   // blue, green, red
    input  logic                       s_axis_tuser,   // func: 1 = drain
    // output pixels
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // out_blue, out_green, out_red
    output logic                       m_axis_tlast    // last_pixel
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = gmbb_pkg::SLOT_W;
    localparam int IRW   = gmbb_pkg::IN_ROW_W;
    localparam int ORW   = gmbb_pkg::OUT_ROW_W;
    localparam int HALF  = gmbb_pkg::HALF;
    localparam int SLOTS = gmbb_pkg::SLOTS;
    localparam int QD    = gmbb_pkg::OUT_DEPTH;
    localparam int QPW   = $clog2(QD);
    localparam int QCW   = $clog2(QD + 1);
    localparam int QCX   = QCW + 1;

    // configuration
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [EW-1:0] w_eff;
    logic [15:0]   h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'(gmbb_pkg::WIDTH_RESET);
            image_height_reg <= 16'(gmbb_pkg::HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_index == gmbb_pkg::REG_IMAGE_WIDTH)
                image_width_reg <= cfg_wdata[10:0];
            else
                image_height_reg <= cfg_wdata[15:0];
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = EW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = EW'(image_width_reg);
        h_eff = (image_height_reg == '0) ? 16'd1 : image_height_reg;
    end

    // positions
    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [IRW-1:0] in_row_reg,  in_row_next;
    logic [SW-1:0]  in_slot_reg, in_slot_next;
    logic [CW-1:0]  out_col_reg,  out_col_next;
    logic [ORW-1:0] out_row_reg,  out_row_next;
    logic [SW-1:0]  out_slot_reg, out_slot_next;

    logic [7:0]  px_blue, px_green, px_red;
    logic [15:0] gray_sum;
    logic [7:0]  gray_in;
    logic        accept, draining, ignore, step, pix, produce;
    logic        interior, s0_last, in_wrap, out_wrap;
    logic [SW-1:0] old_slot;
    logic [CW-1:0] box_waddr;
    gmbb_pkg::win_ctl_t win_ctl;

    assign px_blue  = s_axis_tdata[7:0];
    assign px_green = s_axis_tdata[15:8];
    assign px_red   = s_axis_tdata[23:16];

    always_comb
    begin
        gray_sum = 16'(gmbb_pkg::W_RED)   * 16'(px_red)
                 + 16'(gmbb_pkg::W_GREEN) * 16'(px_green)
                 + 16'(gmbb_pkg::W_BLUE)  * 16'(px_blue);
        gray_in  = gray_sum[15:8];

        accept   = s_axis_tvalid && s_axis_tready;
        draining = in_row_reg >= IRW'(h_eff);
        ignore   = s_axis_tuser && !draining;
        step     = accept && !ignore;
        pix      = step && !draining;
        produce  = step && (in_row_reg >= IRW'(gmbb_pkg::LAG));

        interior = (out_row_reg >= ORW'(HALF))
                && ((IRW'(out_row_reg) + IRW'(HALF)) < IRW'(h_eff))
                && (out_col_reg >= CW'(HALF))
                && ((EW'(out_col_reg) + EW'(HALF)) < w_eff);
        s0_last  = ((IRW'(out_row_reg) + IRW'(1)) >= IRW'(h_eff))
                && ((EW'(out_col_reg) + EW'(1)) >= w_eff);
        in_wrap  = (EW'(in_col_reg) + EW'(1)) >= w_eff;
        out_wrap = (EW'(out_col_reg) + EW'(1)) >= w_eff;

        // slot of the row leaving the vertical window
        old_slot = (in_slot_reg == SW'(SLOTS - 1)) ? '0 : in_slot_reg + SW'(1);
        // mirrored output column of the window centered HALF columns back
        box_waddr = CW'(w_eff + EW'(HALF - 1) - EW'(in_col_reg));

        win_ctl.pix       = pix;
        win_ctl.row_first = in_row_reg == '0;
        win_ctl.sub_en    = in_row_reg >= IRW'(gmbb_pkg::SPAN);
        win_ctl.box_en    = (in_row_reg >= IRW'(2 * HALF)) && (in_col_reg >= CW'(2 * HALF));
        win_ctl.box_bank  = in_row_reg[0];
    end

    // position update
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        if (step)
        begin
            if (in_wrap)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + IRW'(1);
                in_slot_next = old_slot;
            end
            else
                in_col_next = in_col_reg + CW'(1);
            if (produce)
            begin
                if (s0_last)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                end
                else if (out_wrap)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + ORW'(1);
                    out_slot_next = (out_slot_reg == SW'(SLOTS - 1)) ? '0
                                  : out_slot_reg + SW'(1);
                end
                else
                    out_col_next = out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
        end
    end

    // line memory: {red, green, blue, gray} per slot and column
    logic [31:0] line_mem [SLOTS][MAX_WIDTH];
    logic [7:0]  gray_old_reg;
    logic [23:0] colour_rd_reg;

    always_ff @(posedge clk)
    begin
        if (pix)
            line_mem[in_slot_reg][in_col_reg] <= {px_red, px_green, px_blue, gray_in};
        gray_old_reg  <= line_mem[old_slot][in_col_reg][7:0];
        colour_rd_reg <= line_mem[out_slot_reg][out_col_reg][31:8];
    end

    logic [7:0] box_rdata;

    gmbb_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (win_ctl),
        .col      (in_col_reg),
        .box_waddr(box_waddr),
        .gray_in  (gray_in),
        .gray_old (gray_old_reg),
        .rd_bank  (out_row_reg[0]),
        .rd_col   (out_col_reg),
        .box_rdata(box_rdata)
    );

    // result stage
    logic s1_push_reg;
    logic s1_interior_reg;
    logic s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_push_reg <= 1'b0;
        else
            s1_push_reg <= produce;
    end

    always_ff @(posedge clk)
    begin
        s1_interior_reg <= interior;
        s1_last_reg     <= s0_last;
    end

    // output queue
    logic [24:0]    q_mem [QD];
    logic [QPW-1:0] q_wr_reg, q_rd_reg;
    logic [QCW-1:0] q_count_reg;
    logic           q_push, q_pop;
    logic [24:0]    q_wdata;

    assign q_push  = s1_push_reg;
    assign q_pop   = m_axis_tvalid && m_axis_tready;
    assign q_wdata = {s1_last_reg,
                      s1_interior_reg ? {box_rdata, box_rdata, box_rdata} : colour_rd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (q_push)
                q_wr_reg <= (q_wr_reg == QPW'(QD - 1)) ? '0 : q_wr_reg + QPW'(1);
            if (q_pop)
                q_rd_reg <= (q_rd_reg == QPW'(QD - 1)) ? '0 : q_rd_reg + QPW'(1);
            if (q_push && !q_pop)
                q_count_reg <= q_count_reg + QCW'(1);
            else if (q_pop && !q_push)
                q_count_reg <= q_count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wr_reg] <= q_wdata;
    end

    assign m_axis_tvalid = q_count_reg != '0;
    assign m_axis_tdata  = q_mem[q_rd_reg][23:0];
    assign m_axis_tlast  = q_mem[q_rd_reg][24];
    assign s_axis_tready = (QCX'(q_count_reg) + QCX'(s1_push_reg)) < QCX'(QD);

    `GMBB_NEVER(a_queue_overflow, q_push && !q_pop && q_count_reg == QCW'(QD), "output queue overflow")
    `GMBB_ASSERT(a_frame_restart, (produce && s0_last) |=> (in_row_reg == '0 && out_row_reg == '0 && in_slot_reg == '0), "counters not back at frame start")
    `GMBB_ASSERT(a_queue_drain, (q_pop && !q_push) |=> (q_count_reg == $past(q_count_reg) - QCW'(1)), "queue count did not drop on pop")

endmodule
